// ----- rtl/rounded_rect_span_generator_defines.svh -----
// Assertion macros for the rounded rectangle span generator.
`ifndef ROUNDED_RECT_SPAN_GENERATOR_DEFINES_SVH
`define ROUNDED_RECT_SPAN_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define RRSG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("span generator check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define RRSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("span generator check failed");

`endif

// ----- rtl/rrsg_pkg.sv -----
// Types and fixed widths shared by the span generator modules.
package rrsg_pkg;

    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int R_W    = 6;
    localparam int L_W    = 6;
    localparam int B_W    = 7;
    localparam int Q_W    = 12;
    localparam int ROOT_W = 6;
    localparam int REM_W  = 7;
    localparam int CNT_W  = 3;
    localparam logic [CNT_W-1:0] MUL_STEPS  = 3'd6;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 3'd6;

    typedef struct packed {
        logic [X_W-1:0] start_x;
        logic [Y_W-1:0] start_y;
        logic [X_W-1:0] end_x;
        logic [Y_W-1:0] end_y;
        logic [R_W-1:0] corner_radius;
        logic           filled;
    } rrsg_cmd_t;

    typedef struct packed {
        logic [Y_W-1:0] row;
        logic [X_W-1:0] span_from;
        logic [X_W-1:0] span_to;
        logic           ends_only;
        logic           last_span;
    } rrsg_span_t;

endpackage

// ----- rtl/rrsg_mul.sv -----
// Serial shift-add multiplier, one multiplier bit per cycle.
module rrsg_mul
    import rrsg_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [L_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [Q_W-1:0] product
);

    localparam int ACC_W = L_W + B_W;

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [L_W-1:0]   mp_reg,   mp_next;
    logic [ACC_W-1:0] mc_reg,   mc_next;
    logic [ACC_W-1:0] acc_reg,  acc_next;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mp_next   = mp_reg;
        mc_next   = mc_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = MUL_STEPS;
            mp_next  = a;
            mc_next  = {{L_W{1'b0}}, b};
            acc_next = '0;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + (mp_reg[0] ? mc_reg : '0);
            mc_next  = {mc_reg[ACC_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[L_W-1:1]};
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mp_reg  <= mp_next;
        mc_reg  <= mc_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg[Q_W-1:0];

endmodule

// ----- rtl/rrsg_sqrt.sv -----
// Serial restoring integer square root, two radicand bits per cycle.
module rrsg_sqrt
    import rrsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [Q_W-1:0]    radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int SH_W = REM_W + 2;

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [Q_W-1:0]    rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SH_W-1:0]   rem_sh;
    logic [SH_W-1:0]   trial;
    logic [SH_W-1:0]   diff;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[Q_W-1:Q_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = SQRT_STEPS;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[Q_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/rounded_rect_span_generator.sv -----
// Rounded rectangle span generator: row sequencer around serial multiply and square root.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------
//  command  | in        | transfer when start&!busy | cmd    (rrsg_cmd_t)
//  span     | out       | transfer when strobe      | result (rrsg_span_t)
//
//  One span per row, top to bottom. A corner row passes through the bit-serial
//  multiplier and square root, 6 steps each; a middle row skips both.
//  Up to 2*radius rows are corner rows. busy is high from command transfer to the
//  last span. Reset clears the sequencer and both serial units; the consumer cannot
//  stall.
`include "rounded_rect_span_generator_defines.svh"

module rounded_rect_span_generator
    import rrsg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int MAX_RADIUS    = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  rrsg_cmd_t  cmd,
    output logic       busy,
    output logic       strobe,
    output rrsg_span_t result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROW  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [8:0] ROW_MAX = 9'(SCREEN_HEIGHT - 1);
    localparam logic [8:0] COL_MAX = 9'(SCREEN_WIDTH - 1);
    localparam logic [8:0] RAD_MAX = 9'(MAX_RADIUS);

    logic [2:0]        state_reg, state_next;
    logic [X_W-1:0]    sx_reg,    sx_next;
    logic [X_W-1:0]    ex_reg,    ex_next;
    logic [Y_W-1:0]    sy_reg,    sy_next;
    logic [Y_W-1:0]    ey_reg,    ey_next;
    logic [Y_W-1:0]    last_reg,  last_next;
    logic [Y_W-1:0]    y_reg,     y_next;
    logic [R_W-1:0]    r_reg,     r_next;
    logic              fill_reg,  fill_next;
    logic [R_W-1:0]    off_reg,   off_next;
    logic              strobe_reg, strobe_next;
    rrsg_span_t        out_reg,   out_next;

    logic [R_W-1:0]    r_in;
    logic [Y_W-1:0]    last_in;
    logic              is_top;
    logic              is_bot;
    logic [L_W-1:0]    l_val;
    logic [B_W-1:0]    b_val;
    logic              mul_start;
    logic              mul_done;
    logic [Q_W-1:0]    product;
    logic              sqrt_done;
    logic [ROOT_W-1:0] root;
    logic [8:0]        from_w;
    logic [8:0]        to_w;

    rrsg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (l_val),
        .b       (b_val),
        .done    (mul_done),
        .product (product)
    );

    rrsg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_done),
        .radicand (product),
        .done     (sqrt_done),
        .root     (root)
    );

    always_comb
    begin
        r_in    = ({3'b000, cmd.corner_radius} > RAD_MAX) ? RAD_MAX[R_W-1:0]
                                                          : cmd.corner_radius;
        last_in = ({3'b000, cmd.end_y} > ROW_MAX) ? ROW_MAX[Y_W-1:0] : cmd.end_y;

        is_top    = {1'b0, y_reg} < ({1'b0, sy_reg} + {1'b0, r_reg});
        is_bot    = ({1'b0, y_reg} + {1'b0, r_reg}) > {1'b0, ey_reg};
        l_val     = is_top ? (y_reg - sy_reg) : (ey_reg - y_reg);
        b_val     = {r_reg, 1'b0} - 7'd2 - {1'b0, l_val};
        mul_start = (state_reg == ST_ROW) && (is_top || is_bot);

        from_w = {2'b00, sx_reg} + {3'b000, off_reg};
        to_w   = {2'b00, ex_reg} - {3'b000, off_reg};

        state_next  = state_reg;
        sx_next     = sx_reg;
        ex_next     = ex_reg;
        sy_next     = sy_reg;
        ey_next     = ey_reg;
        last_next   = last_reg;
        y_next      = y_reg;
        r_next      = r_reg;
        fill_next   = fill_reg;
        off_next    = off_reg;
        strobe_next = 1'b0;
        out_next    = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sx_next   = cmd.start_x;
                    ex_next   = cmd.end_x;
                    sy_next   = cmd.start_y;
                    ey_next   = cmd.end_y;
                    last_next = last_in;
                    y_next    = cmd.start_y;
                    r_next    = r_in;
                    fill_next = cmd.filled;
                    if (cmd.start_y <= last_in)
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                if (is_top || is_bot)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    off_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    off_next   = r_reg - 6'd1 - root;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next        = 1'b1;
                out_next.row       = y_reg;
                out_next.span_from = (from_w > COL_MAX) ? COL_MAX[X_W-1:0]
                                                        : from_w[X_W-1:0];
                out_next.span_to   = to_w[8] ? '0 : to_w[X_W-1:0];
                out_next.ends_only = !fill_reg && (y_reg != sy_reg) && (y_reg != ey_reg);
                out_next.last_span = (y_reg == last_reg);
                if (y_reg == last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    y_next     = y_reg + 6'd1;
                    state_next = ST_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg   <= sx_next;
        ex_reg   <= ex_next;
        sy_reg   <= sy_next;
        ey_reg   <= ey_next;
        last_reg <= last_next;
        y_reg    <= y_next;
        r_reg    <= r_next;
        fill_reg <= fill_next;
        off_reg  <= off_next;
        out_reg  <= out_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = out_reg;

    `RRSG_ASSERT_NEXT(a_emit_strobes, state_reg == ST_EMIT, strobe)
    `RRSG_ASSERT_NOW(a_last_frees, strobe && result.last_span, !busy)
    `RRSG_ASSERT_NOW(a_more_busy, strobe && !result.last_span, busy)
    `RRSG_ASSERT_NOW(a_mul_only_corner, mul_done, state_reg == ST_MUL)

endmodule

// ----- bench/rounded_rect_span_generator_tb.sv -----
// Self-checking testbench for the rounded rectangle span generator.
module rounded_rect_span_generator_tb;
    import rrsg_pkg::*;

    localparam int SCR_W       = 128;
    localparam int SCR_H       = 64;
    localparam int MAX_R       = 32;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 64;

    logic       clk;
    logic       rst_n;
    logic       start;
    rrsg_cmd_t  cmd;
    logic       busy;
    logic       strobe;
    rrsg_span_t result;

    rrsg_cmd_t  pend_cmds[$];
    rrsg_span_t exp_spans[$];
    int         err_cnt;
    int         quiet_cycles;
    int         idle_pct;

    rounded_rect_span_generator #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H),
        .MAX_RADIUS    (MAX_R)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void predict_spans(rrsg_cmd_t c);
        int sx, sy, ex, ey, rad, bottom, y, lo, hi, gap, prod, root, inset;
        rrsg_span_t s;
        sx = c.start_x;
        sy = c.start_y;
        ex = c.end_x;
        ey = c.end_y;
        rad = (c.corner_radius > MAX_R) ? MAX_R : c.corner_radius;
        bottom = (ey > SCR_H - 1) ? SCR_H - 1 : ey;
        for (y = sy; y <= bottom; y++)
        begin
            lo = sx;
            hi = ex;
            gap = -1;
            if (y < sy + rad)
                gap = y - sy;
            else if (y >= ey - rad + 1)
                gap = ey - y;
            if (gap >= 0)
            begin
                prod = gap * (2 * rad - 2 - gap);
                if (prod < 0)
                    prod = 0;
                root = 0;
                while ((root + 1) * (root + 1) <= prod)
                    root++;
                inset = rad - 1 - root;
                if (inset < 0)
                    inset = 0;
                lo = sx + inset;
                hi = ex - inset;
            end
            if (lo > SCR_W - 1)
                lo = SCR_W - 1;
            if (hi < 0)
                hi = 0;
            s.row       = y[Y_W-1:0];
            s.span_from = lo[X_W-1:0];
            s.span_to   = hi[X_W-1:0];
            s.ends_only = !c.filled && y != sy && y != ey;
            s.last_span = (y == bottom);
            exp_spans.push_back(s);
        end
    endfunction

    function automatic void push_rect(int sx, int sy, int ex, int ey, int rad, bit fill);
        rrsg_cmd_t c;
        c.start_x       = sx[X_W-1:0];
        c.start_y       = sy[Y_W-1:0];
        c.end_x         = ex[X_W-1:0];
        c.end_y         = ey[Y_W-1:0];
        c.corner_radius = rad[R_W-1:0];
        c.filled        = fill;
        pend_cmds.push_back(c);
    endfunction

    // mostly well-formed rectangles, some with arbitrary fields (empty, crossed, oversize radius)
    task automatic queue_random_rects(int count);
        int i, sx, sy, ex, ey, rad;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 15)
            begin
                push_rect($urandom_range(127), $urandom_range(63), $urandom_range(127),
                          $urandom_range(63), $urandom_range(63), $urandom_range(1));
            end
            else
            begin
                sx = $urandom_range(127);
                ex = $urandom_range(127, sx);
                sy = $urandom_range(63);
                ey = ($urandom_range(3) == 0) ? $urandom_range(63, sy)
                                              : $urandom_range((sy + 20 > 63) ? 63 : sy + 20, sy);
                rad = ($urandom_range(9) == 0) ? $urandom_range(63, 33) : $urandom_range(32);
                push_rect(sx, sy, ex, ey, rad, $urandom_range(1));
            end
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (pend_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
        begin
            start <= 1'b1;
            cmd   <= pend_cmds[0];
        end
        else
            start <= 1'b0;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        rrsg_span_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_spans(pend_cmds[0]);
                void'(pend_cmds.pop_front());
            end
            if (strobe)
            begin
                if (exp_spans.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected span: row %0d from %0d to %0d ends %0b last %0b",
                                 result.row, result.span_from, result.span_to,
                                 result.ends_only, result.last_span);
                    err_cnt++;
                end
                else
                begin
                    want = exp_spans.pop_front();
                    if (result.row !== want.row || result.span_from !== want.span_from ||
                        result.span_to !== want.span_to || result.ends_only !== want.ends_only ||
                        result.last_span !== want.last_span)
                    begin
                        if (err_cnt < 10)
                            $display({"span mismatch: exp row %0d from %0d to %0d ends %0b ",
                                      "last %0b, got row %0d from %0d to %0d ends %0b last %0b"},
                                     want.row, want.span_from, want.span_to, want.ends_only,
                                     want.last_span, result.row, result.span_from,
                                     result.span_to, result.ends_only, result.last_span);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        err_cnt      = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_rect(0, 0, 127, 63, 0, 1);
        push_rect(0, 0, 127, 63, 32, 0);
        push_rect(0, 0, 127, 63, 32, 1);
        push_rect(10, 5, 100, 40, 63, 1);
        push_rect(10, 5, 100, 40, 33, 0);
        push_rect(5, 40, 100, 10, 3, 1);
        push_rect(3, 7, 50, 7, 4, 0);
        push_rect(3, 7, 50, 7, 0, 1);
        push_rect(100, 10, 20, 20, 5, 1);
        push_rect(100, 10, 20, 20, 5, 0);
        push_rect(127, 0, 127, 10, 8, 0);
        push_rect(0, 0, 0, 10, 8, 1);
        push_rect(5, 5, 20, 15, 1, 0);
        push_rect(5, 5, 20, 15, 2, 1);
        push_rect(10, 10, 60, 14, 20, 1);
        push_rect(10, 10, 60, 15, 20, 0);
        push_rect(127, 63, 127, 63, 63, 1);
        push_rect(0, 0, 0, 0, 0, 0);
        push_rect(0, 63, 127, 63, 1, 0);
        push_rect(40, 20, 80, 43, 12, 0);
        while (pend_cmds.size() != 0)
            @(posedge clk);

        queue_random_rects(48);
        while (pend_cmds.size() != 0)
            @(posedge clk);
        idle_pct = 57;
        queue_random_rects(48);
        while (pend_cmds.size() != 0)
            @(posedge clk);
        idle_pct = 0;
        queue_random_rects(47);
        while (pend_cmds.size() != 0)
            @(posedge clk);
        idle_pct = 25;
        queue_random_rects(47);

        while (pend_cmds.size() != 0 || exp_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
